@@ rtl/layered_rect_hit_test_defines.svh @@
// Assertion macros used by the checker of the hit test block.
`ifndef LAYERED_RECT_HIT_TEST_DEFINES_SVH
`define LAYERED_RECT_HIT_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hit test check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hit test check failed");

`endif

@@ rtl/rht_pkg.sv @@
`timescale 1ns / 1ps

package rht_pkg;

    localparam int unsigned CoordWidth  = 16;
    localparam int unsigned KeyWidth    = 16;
    localparam int unsigned EntityWidth = 32;

    typedef struct packed {
        logic signed [CoordWidth-1:0] cursor_x;
        logic signed [CoordWidth-1:0] cursor_y;
        logic signed [CoordWidth-1:0] region_left;
        logic signed [CoordWidth-1:0] region_top;
        logic signed [CoordWidth-1:0] region_width;
        logic signed [CoordWidth-1:0] region_height;
        logic                         region_enabled;
        logic signed [KeyWidth-1:0]   region_layer;
        logic signed [KeyWidth-1:0]   region_depth_order;
        logic        [KeyWidth-1:0]   region_sequence;
        logic        [EntityWidth-1:0] region_entity;
        logic                         last_region;
    } region_t;

    typedef struct packed {
        logic                          valid;
        logic signed [KeyWidth-1:0]    layer;
        logic signed [KeyWidth-1:0]    depth_order;
        logic        [KeyWidth-1:0]    seq_num;
        logic        [EntityWidth-1:0] entity;
    } best_t;

endpackage

@@ rtl/rht_channels.sv @@
`timescale 1ns / 1ps

interface rht_item_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic signed [15:0] region_left;
    logic signed [15:0] region_top;
    logic signed [15:0] region_width;
    logic signed [15:0] region_height;
    logic               region_enabled;
    logic signed [15:0] region_layer;
    logic signed [15:0] region_depth_order;
    logic        [15:0] region_sequence;
    logic        [31:0] region_entity;
    logic               last_region;

    modport source (
        output valid, cursor_x, cursor_y, region_left, region_top, region_width,
               region_height, region_enabled, region_layer, region_depth_order,
               region_sequence, region_entity, last_region,
        input  ready
    );

    modport sink (
        input  valid, cursor_x, cursor_y, region_left, region_top, region_width,
               region_height, region_enabled, region_layer, region_depth_order,
               region_sequence, region_entity, last_region,
        output ready
    );
endinterface

interface rht_result_if;
    logic        valid;
    logic        ready;
    logic        hit_found;
    logic [31:0] hit_entity;

    modport source (
        output valid, hit_found, hit_entity,
        input  ready
    );

    modport sink (
        input  valid, hit_found, hit_entity,
        output ready
    );
endinterface

@@ rtl/rht_hit.sv @@
`timescale 1ns / 1ps

module rht_hit (
    input  rht_pkg::region_t region,
    output logic             hit
);
    import rht_pkg::*;

    logic signed [CoordWidth:0] right;
    logic signed [CoordWidth:0] bottom;
    logic signed [CoordWidth:0] cx;
    logic signed [CoordWidth:0] cy;
    logic signed [CoordWidth:0] left;
    logic signed [CoordWidth:0] top;
    logic                       size_ok;

    // Edges are one bit wider than the fields so the sums never wrap.
    always_comb
    begin
        cx     = {region.cursor_x[CoordWidth-1], region.cursor_x};
        cy     = {region.cursor_y[CoordWidth-1], region.cursor_y};
        left   = {region.region_left[CoordWidth-1], region.region_left};
        top    = {region.region_top[CoordWidth-1], region.region_top};
        right  = left + {region.region_width[CoordWidth-1], region.region_width};
        bottom = top + {region.region_height[CoordWidth-1], region.region_height};
        size_ok = (region.region_width > $signed(CoordWidth'(0)))
               && (region.region_height > $signed(CoordWidth'(0)));
        hit = region.region_enabled && size_ok
           && (cx >= left) && (cx < right)
           && (cy >= top) && (cy < bottom);
    end
endmodule

@@ rtl/rht_best.sv @@
`timescale 1ns / 1ps

module rht_best (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             hit,
    input  rht_pkg::region_t region,
    output rht_pkg::best_t   merged
);
    import rht_pkg::*;

    best_t best_reg;
    best_t best_next;
    best_t candidate;
    logic  outranks;
    logic  take;

    // A later region must be strictly higher on the first key that differs.
    always_comb
    begin
        if (region.region_layer != best_reg.layer)
        begin
            outranks = region.region_layer > best_reg.layer;
        end
        else if (region.region_depth_order != best_reg.depth_order)
        begin
            outranks = region.region_depth_order > best_reg.depth_order;
        end
        else
        begin
            outranks = region.region_sequence > best_reg.seq_num;
        end

        candidate.valid       = 1'b1;
        candidate.layer       = region.region_layer;
        candidate.depth_order = region.region_depth_order;
        candidate.seq_num     = region.region_sequence;
        candidate.entity      = region.region_entity;

        take   = hit && (!best_reg.valid || outranks);
        merged = take ? candidate : best_reg;

        if (!advance)
        begin
            best_next = best_reg;
        end
        else if (region.last_region)
        begin
            best_next = '0;
        end
        else
        begin
            best_next = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end
endmodule

@@ rtl/layered_rect_hit_test.sv @@
`timescale 1ns / 1ps

// Layered rectangle hit test. Regions of one query stream in on the item channel, one
// transfer per cycle unless it stalls, each with the cursor point; the last region of
// a query carries last_region. Each item is held in an input register, tested for
// containment and ranked against the running best in one pass, and the query result
// (hit_found and hit_entity of the highest region by layer, depth order, then sequence)
// leaves through an output register once the last region is retired from the input
// register. The item channel only stalls while a finished result waits in the output
// register and the next query's last region is already staged behind it.
module layered_rect_hit_test (
    input logic         clk,
    input logic         rst_n,
    rht_item_if.sink    item,
    rht_result_if.source result
);
    import rht_pkg::*;

    region_t               s1_item_reg;
    region_t               s1_item_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_retire;
    logic                  accept;
    logic                  hit;
    best_t                 merged;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_found_reg;
    logic                  out_found_next;
    logic [EntityWidth-1:0] out_entity_reg;
    logic [EntityWidth-1:0] out_entity_next;

    rht_hit u_hit (
        .region (s1_item_reg),
        .hit    (hit)
    );

    rht_best u_best (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_retire),
        .hit     (hit),
        .region  (s1_item_reg),
        .merged  (merged)
    );

    always_comb
    begin
        s1_retire  = s1_valid_reg
                  && (!s1_item_reg.last_region || !out_valid_reg || result.ready);
        item.ready = !s1_valid_reg || s1_retire;
        accept     = item.valid && item.ready;

        s1_item_next.cursor_x           = item.cursor_x;
        s1_item_next.cursor_y           = item.cursor_y;
        s1_item_next.region_left        = item.region_left;
        s1_item_next.region_top         = item.region_top;
        s1_item_next.region_width       = item.region_width;
        s1_item_next.region_height      = item.region_height;
        s1_item_next.region_enabled     = item.region_enabled;
        s1_item_next.region_layer       = item.region_layer;
        s1_item_next.region_depth_order = item.region_depth_order;
        s1_item_next.region_sequence    = item.region_sequence;
        s1_item_next.region_entity      = item.region_entity;
        s1_item_next.last_region        = item.last_region;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_found_next  = out_found_reg;
        out_entity_next = out_entity_reg;
        if (s1_retire && s1_item_reg.last_region)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = merged.valid;
            out_entity_next = merged.valid ? merged.entity : '0;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        result.valid      = out_valid_reg;
        result.hit_found  = out_found_reg;
        result.hit_entity = out_entity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
        out_found_reg  <= out_found_next;
        out_entity_reg <= out_entity_next;
    end
endmodule

@@ rtl/rht_checker.sv @@
`timescale 1ns / 1ps
`include "layered_rect_hit_test_defines.svh"

module rht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        result_hit_found,
    input logic [31:0] result_hit_entity
);
    logic        result_stall;
    logic        result_miss;
    logic [32:0] result_data;

    assign result_stall = result_valid && !result_ready;
    assign result_miss  = result_valid && !result_hit_found;
    assign result_data  = {result_hit_found, result_hit_entity};

    // A stalled result keeps its payload until the transfer.
    `RHT_ASSERT_NEXT(a_result_hold, clk, rst_n, result_stall, result_valid && $stable(result_data))

    // A miss always reports a zero entity.
    `RHT_ASSERT_SAME(a_miss_zero, clk, rst_n, result_miss, result_hit_entity == 32'd0)

    // The item side only stalls behind a result that is still waiting.
    `RHT_ASSERT_SAME(a_stall_cause, clk, rst_n, !item_ready, result_valid)
endmodule

bind layered_rect_hit_test rht_checker u_rht_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_hit_found  (result.hit_found),
    .result_hit_entity (result.hit_entity)
);

@@ bench/layered_rect_hit_test_test.sv @@
`timescale 1ns / 1ps

module layered_rect_hit_test_test;
    import rht_pkg::*;

    localparam int ClkHalf       = 6;
    localparam int ResetCycles   = 7;
    localparam int RegionTarget  = 1800;
    localparam int CycleLimit    = 200000;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 10;

    typedef struct packed {
        logic        found;
        logic [31:0] entity;
    } hit_outcome_t;

    class hit_scoreboard;
        logic               best_valid;
        logic signed [15:0] best_layer;
        logic signed [15:0] best_depth;
        logic        [15:0] best_seq;
        logic        [31:0] best_entity;
        hit_outcome_t       outcomes[$];
        int                 regions_seen;
        int                 queries_checked;
        int                 hits_seen;
        int                 errors;

        function new();
            clear_best();
            regions_seen    = 0;
            queries_checked = 0;
            hits_seen       = 0;
            errors          = 0;
        endfunction

        function void clear_best();
            best_valid  = 1'b0;
            best_layer  = '0;
            best_depth  = '0;
            best_seq    = '0;
            best_entity = '0;
        endfunction

        function bit holds_cursor(region_t r);
            int cx;
            int cy;
            int l;
            int t;
            int w;
            int h;
            cx = $signed(r.cursor_x);
            cy = $signed(r.cursor_y);
            l  = $signed(r.region_left);
            t  = $signed(r.region_top);
            w  = $signed(r.region_width);
            h  = $signed(r.region_height);
            if (!r.region_enabled || w <= 0 || h <= 0)
            begin
                return 1'b0;
            end
            return cx >= l && cx < l + w && cy >= t && cy < t + h;
        endfunction

        function bit beats_best(region_t r);
            if (r.region_layer != best_layer)
            begin
                return $signed(r.region_layer) > $signed(best_layer);
            end
            if (r.region_depth_order != best_depth)
            begin
                return $signed(r.region_depth_order) > $signed(best_depth);
            end
            return r.region_sequence > best_seq;
        endfunction

        function void note_region(region_t r);
            hit_outcome_t o;
            regions_seen++;
            if (holds_cursor(r) && (!best_valid || beats_best(r)))
            begin
                best_valid  = 1'b1;
                best_layer  = r.region_layer;
                best_depth  = r.region_depth_order;
                best_seq    = r.region_sequence;
                best_entity = r.region_entity;
            end
            if (r.last_region)
            begin
                o.found  = best_valid;
                o.entity = best_valid ? best_entity : 32'd0;
                outcomes.push_back(o);
                clear_best();
            end
        endfunction

        function void check_result(logic found, logic [31:0] entity);
            hit_outcome_t o;
            if (outcomes.size() == 0)
            begin
                $error("Unexpected result: hit_found %0b, hit_entity 0x%08h", found, entity);
                errors++;
                return;
            end
            o = outcomes.pop_front();
            queries_checked++;
            if (o.found)
            begin
                hits_seen++;
            end
            if (found !== o.found)
            begin
                $error("hit_found mismatch: expected %0b, actual %0b", o.found, found);
                errors++;
            end
            if (entity !== o.entity)
            begin
                $error("hit_entity mismatch: expected 0x%08h, actual 0x%08h", o.entity, entity);
                errors++;
            end
        endfunction

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   regions_sent;

    hit_scoreboard sb = new();

    rht_item_if   item_ch();
    rht_result_if result_ch();

    layered_rect_hit_test u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(ClkHalf) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            sb.note_region(region_t'({item_ch.cursor_x, item_ch.cursor_y,
                item_ch.region_left, item_ch.region_top, item_ch.region_width,
                item_ch.region_height, item_ch.region_enabled, item_ch.region_layer,
                item_ch.region_depth_order, item_ch.region_sequence,
                item_ch.region_entity, item_ch.last_region}));
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_result(result_ch.hit_found, result_ch.hit_entity);
        end
    end

    task automatic drive_fields(input region_t r);
        item_ch.cursor_x           <= r.cursor_x;
        item_ch.cursor_y           <= r.cursor_y;
        item_ch.region_left        <= r.region_left;
        item_ch.region_top         <= r.region_top;
        item_ch.region_width       <= r.region_width;
        item_ch.region_height      <= r.region_height;
        item_ch.region_enabled     <= r.region_enabled;
        item_ch.region_layer       <= r.region_layer;
        item_ch.region_depth_order <= r.region_depth_order;
        item_ch.region_sequence    <= r.region_sequence;
        item_ch.region_entity      <= r.region_entity;
        item_ch.last_region        <= r.last_region;
    endtask

    task automatic send_region(input region_t r);
        bit calm;
        calm = regions_sent >= 900 && regions_sent < 1200;
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        drive_fields(r);
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        regions_sent++;
    endtask

    function automatic region_t make_region(int cx, int cy, int l, int t, int w, int h,
                                            bit en, int layer, int depth, int seq,
                                            logic [31:0] ent, bit last);
        region_t r;
        r.cursor_x           = 16'(cx);
        r.cursor_y           = 16'(cy);
        r.region_left        = 16'(l);
        r.region_top         = 16'(t);
        r.region_width       = 16'(w);
        r.region_height      = 16'(h);
        r.region_enabled     = en;
        r.region_layer       = 16'(layer);
        r.region_depth_order = 16'(depth);
        r.region_sequence    = 16'(seq);
        r.region_entity      = ent;
        r.last_region        = last;
        return r;
    endfunction

    function automatic int pick_key();
        if ($urandom_range(0, 99) < 70)
        begin
            return int'($urandom_range(0, 4)) - 2;
        end
        return int'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_span();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            4: return 32767;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int near_edge(int c, int span);
        int e;
        e = c - int'($urandom_range(0, span));
        return (e < -32768) ? -32768 : e;
    endfunction

    function automatic region_t random_region(int cx, int cy, bit last);
        int w;
        int h;
        int mode;
        region_t r;
        mode = $urandom_range(0, 99);
        if (mode < 60)
        begin
            w = $urandom_range(1, 200);
            h = $urandom_range(1, 200);
            r = make_region(cx, cy, near_edge(cx, w), near_edge(cy, h), w, h, 1'b1,
                            pick_key(), pick_key(), pick_key(), $urandom, last);
        end
        else if (mode < 80)
        begin
            r = make_region(cx, cy, $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1,
                            pick_key(), pick_key(), pick_key(), $urandom, last);
        end
        else
        begin
            w = pick_span();
            h = pick_span();
            r = make_region(cx, cy, near_edge(cx, 4), near_edge(cy, 4), w, h, 1'b1,
                            pick_key(), pick_key(), pick_key(), $urandom, last);
        end
        r.region_enabled = $urandom_range(0, 99) < 85;
        return r;
    endfunction

    task automatic run_directed();
        // Single unit region at the origin.
        send_region(make_region(0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 1));
        // Misses: cursor on the exclusive right edge, disabled region, cursor on the exclusive bottom edge, zero width.
        send_region(make_region(10, 5, 0, 0, 10, 10, 1, 0, 0, 0, 32'h11, 0));
        send_region(make_region(5, 5, 0, 0, 10, 10, 0, 9, 0, 0, 32'h12, 0));
        send_region(make_region(5, 10, 0, 0, 10, 10, 1, 0, 0, 0, 32'h13, 0));
        send_region(make_region(5, 5, 0, 0, 0, 10, 1, 0, 0, 0, 32'h14, 1));
        // Coordinate extremes, wide right and bottom edges, cursor moving in the query.
        send_region(make_region(32767, 32767, 32767, 32767, 32767, 32767, 1,
                                -32768, -32768, 0, 32'h1, 0));
        send_region(make_region(-32768, -32768, -32768, -32768, 32767, 32767, 1,
                                32767, 32767, 65535, 32'h2, 0));
        send_region(make_region(0, 0, -32768, -32768, -32768, 32767, 1,
                                32767, 32767, 65535, 32'h3, 0));
        send_region(make_region(0, 0, -32768, -32768, 32767, -1, 1,
                                32767, 32767, 65535, 32'h4, 1));
        // Equal keys keep the earlier region; each later key decides in turn.
        send_region(make_region(3, 3, 0, 0, 8, 8, 1, 1, 1, 1, 32'hA, 0));
        send_region(make_region(3, 3, 0, 0, 8, 8, 1, 1, 1, 1, 32'hB, 0));
        send_region(make_region(3, 3, 0, 0, 8, 8, 1, 1, 1, 2, 32'hC, 0));
        send_region(make_region(3, 3, 0, 0, 8, 8, 1, 1, 2, 0, 32'hD, 0));
        send_region(make_region(3, 3, 0, 0, 8, 8, 1, -1, 5, 9, 32'hE, 1));
        // The last region takes part before the result leaves.
        send_region(make_region(-7, -7, -10, -10, 4, 4, 1, 5, 0, 0, 32'h51, 0));
        send_region(make_region(-7, -7, -7, -7, 1, 1, 1, 6, 0, 0, 32'h52, 1));
        // Cursor above the top and on the bottom edge.
        send_region(make_region(2, -1, 0, 0, 4, 4, 1, 0, 0, 0, 32'h61, 0));
        send_region(make_region(2, 4, 0, 0, 4, 4, 1, 0, 0, 0, 32'h62, 1));
        // Back-to-back queries of one region each.
        send_region(make_region(100, 200, 99, 199, 2, 2, 1, 0, 0, 0, 32'h71, 1));
        send_region(make_region(100, 200, 101, 199, 2, 2, 1, 0, 0, 0, 32'h72, 1));
    endtask

    task automatic run_random();
        int cx;
        int cy;
        int qlen;
        region_t r;
        while (regions_sent < RegionTarget)
        begin
            qlen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            if ($urandom_range(0, 99) < 70)
            begin
                cx = int'($urandom_range(0, 1000)) - 500;
                cy = int'($urandom_range(0, 1000)) - 500;
            end
            else
            begin
                cx = $signed(16'($urandom_range(0, 65535)));
                cy = $signed(16'($urandom_range(0, 65535)));
            end
            for (int i = 0; i < qlen; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    cx = $signed(16'($urandom_range(0, 65535)));
                    cy = $signed(16'($urandom_range(0, 65535)));
                end
                r = random_region(cx, cy, i == qlen - 1);
                send_region(r);
            end
        end
    endtask

    initial
    begin
        int hold_count;
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && sb.regions_seen >= 600)
            begin
                held = 1'b1;
                hold_count = 0;
                while (hold_count < HoldOffCycles)
                begin
                    result_ch.ready <= 1'b0;
                    @(posedge clk);
                    hold_count++;
                end
            end
            if (sb.queries_checked >= 150 && sb.queries_checked < 260)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= $urandom_range(0, 99) >= 13;
            end
        end
    end

    initial
    begin
        cycle_count   = 0;
        regions_sent  = 0;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        drive_fields('0);
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0 || sb.regions_seen != regions_sent)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d regions in %0d queries; %0d queries found a hit.",
                 sb.regions_seen, sb.queries_checked, sb.hits_seen);
        $display("Covered edge and wrap cases, key ties, a long output stall and %0d errors.",
                 sb.errors);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
